// ===== rtl/vegetation_index_pixel_macros.svh =====
// Assertion helpers for the vegetation index block.
`ifndef VEGETATION_INDEX_PIXEL_MACROS_SVH
`define VEGETATION_INDEX_PIXEL_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define VIP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define VIP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/vip_pkg.sv =====
`timescale 1ns / 1ps
package vip_pkg;

  localparam int REM_W   = 17;

  localparam logic [15:0] SCALED_MAX = 16'd65280;
  localparam logic [16:0] VI_DIVISOR = 17'd65280;

  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  typedef enum logic [2:0] {
    CFG_VIS_CH   = 3'd0,
    CFG_NIR_CH   = 3'd1,
    CFG_VIS_OFF  = 3'd2,
    CFG_VIS_GAIN = 3'd3,
    CFG_NIR_OFF  = 3'd4,
    CFG_NIR_GAIN = 3'd5,
    CFG_MODE     = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [1:0]  vis_ch;
    logic [1:0]  nir_ch;
    logic [8:0]  vis_off;
    logic [11:0] vis_gain;
    logic [8:0]  nir_off;
    logic [11:0] nir_gain;
    logic        mode;
  } cfg_t;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [REM_W-1:0] den;
    logic             neg;
    logic             undef;
  } div_word_t;

endpackage

// ===== rtl/vip_pixel_if.sv =====
`timescale 1ns / 1ps
interface vip_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_level;
  logic [7:0] green_level;
  logic [7:0] blue_level;

  modport source (output valid, red_level, green_level, blue_level, input ready);
  modport sink (input valid, red_level, green_level, blue_level, output ready);
endinterface

// ===== rtl/vip_index_if.sv =====
`timescale 1ns / 1ps
interface vip_index_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] index_value;
  logic               undefined_flag;

  modport source (output valid, index_value, undefined_flag, input ready);
  modport sink (input valid, index_value, undefined_flag, output ready);
endinterface

// ===== rtl/vegetation_index_pixel.sv =====
`timescale 1ns / 1ps
// Vegetation index of one RGB pixel per request.
// The pixel_i channel takes red, green and blue levels; the index_o channel
// returns the signed index with INDEX_FRAC_BITS fraction bits and a flag that
// is set when the normalised denominator is zero (the index is then zero).
// Both channels use a valid/ready handshake; a request moves when both are high.
// Registers are written through cfg_we_i, cfg_idx_i and cfg_data_i; the user
// must write them only while the block is idle, as the block does not enforce
// it; unknown indices are ignored. The stages are a scaling stage with the gain
// multiplier, a clamp and difference stage, one divider cell per fraction bit
// and the output register. Throughput is one pixel per cycle while the
// receiver keeps up; each restoring-division cell resolves one quotient bit.
// Reset empties every stage and loads the default register values.
// When the receiver stalls, each stage holds its request and the empty stages
// behind it keep filling, so new pixels are taken until the row is full.
module vegetation_index_pixel import vip_pkg::*; #(
  parameter int INDEX_FRAC_BITS = 14
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  vip_pixel_if.sink    pixel_i,
  vip_index_if.source  index_o,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [11:0]  cfg_data_i
);

  `include "vegetation_index_pixel_macros.svh"

  localparam int F  = INDEX_FRAC_BITS;
  localparam int QW = F + 1;
  localparam int QX = (QW > 17) ? QW : 17;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.vis_ch   <= CH_BLUE;
      cfg_q.nir_ch   <= CH_RED;
      cfg_q.vis_off  <= 9'd0;
      cfg_q.vis_gain <= 12'd256;
      cfg_q.nir_off  <= 9'd0;
      cfg_q.nir_gain <= 12'd256;
      cfg_q.mode     <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_VIS_CH:   cfg_q.vis_ch   <= cfg_data_i[1:0];
        CFG_NIR_CH:   cfg_q.nir_ch   <= cfg_data_i[1:0];
        CFG_VIS_OFF:  cfg_q.vis_off  <= cfg_data_i[8:0];
        CFG_VIS_GAIN: cfg_q.vis_gain <= cfg_data_i;
        CFG_NIR_OFF:  cfg_q.nir_off  <= cfg_data_i[8:0];
        CFG_NIR_GAIN: cfg_q.nir_gain <= cfg_data_i;
        CFG_MODE:     cfg_q.mode     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic          valid_w [0:F];
  logic          ready_w [0:F];
  div_word_t     word_w  [0:F];
  logic [QW-1:0] quo_w   [0:F];

  vip_front #(.QW(QW)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (pixel_i.valid),
    .ready_o (pixel_i.ready),
    .red_i   (pixel_i.red_level),
    .green_i (pixel_i.green_level),
    .blue_i  (pixel_i.blue_level),
    .valid_o (valid_w[0]),
    .ready_i (ready_w[0]),
    .word_o  (word_w[0]),
    .quo_o   (quo_w[0])
  );

  for (genvar k = 0; k < F; k++) begin : g_cell
    vip_div_cell #(.QW(QW)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_w[k]),
      .ready_o (ready_w[k]),
      .word_i  (word_w[k]),
      .quo_i   (quo_w[k]),
      .valid_o (valid_w[k+1]),
      .ready_i (ready_w[k+1]),
      .word_o  (word_w[k+1]),
      .quo_o   (quo_w[k+1])
    );
  end

  logic               out_valid_q;
  logic signed [15:0] out_index_q;
  logic               out_flag_q;
  logic [QX-1:0]      qx, qm, qn;
  logic signed [15:0] index_d;

  always_comb begin
    qx = QX'(quo_w[F]);
    qm = (qx > QX'(32768)) ? QX'(32768) : qx;
    qn = QX'(0) - qm;
    if (word_w[F].undef) begin
      index_d = '0;
    end else if (word_w[F].neg) begin
      index_d = qn[15:0];
    end else if (qx > QX'(32767)) begin
      index_d = 16'sd32767;
    end else begin
      index_d = qx[15:0];
    end
  end

  assign ready_w[F] = !out_valid_q || index_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ready_w[F]) begin
      out_valid_q <= valid_w[F];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_w[F] && valid_w[F]) begin
      out_index_q <= index_d;
      out_flag_q  <= word_w[F].undef;
    end
  end

  assign index_o.valid          = out_valid_q;
  assign index_o.index_value    = out_index_q;
  assign index_o.undefined_flag = out_flag_q;

  `VIP_ASSERT_NOW(a_flag_zero, out_valid_q && out_flag_q, out_index_q == 16'sd0, "flagged index is not zero")
  `VIP_ASSERT_NOW(a_rem_below_den, valid_w[F] && !word_w[F].undef, word_w[F].rem < word_w[F].den, "divider remainder out of range")
  `VIP_ASSERT_NOW(a_quo_bound, valid_w[F] && !word_w[F].undef, QX'(quo_w[F]) <= (QX'(1) << F), "quotient above one")

endmodule

// ===== rtl/vip_front.sv =====
`timescale 1ns / 1ps
module vip_front import vip_pkg::*; #(
  parameter int QW = 15
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  logic             valid_i,
  output logic             ready_o,
  input  logic [7:0]       red_i,
  input  logic [7:0]       green_i,
  input  logic [7:0]       blue_i,
  output logic             valid_o,
  input  logic             ready_i,
  output div_word_t        word_o,
  output logic [QW-1:0]    quo_o
);

  logic              s1_valid_q;
  logic [20:0]       s1_vis_q, s1_nir_q;
  logic              s1_mode_q;
  logic              s1_ready;
  logic              s2_valid_q;
  logic              s2_ready;
  div_word_t         s2_word_q;
  logic              s2_top_q;

  logic [7:0]        vis_lvl, nir_lvl;
  logic signed [9:0] vis_sum, nir_sum;
  logic [8:0]        vis_pos, nir_pos;
  logic [20:0]       vis_prod, nir_prod;

  logic [15:0]       vis_c, nir_c;
  logic              neg;
  logic [15:0]       mag;
  logic [16:0]       den;
  logic              top;
  div_word_t         word_d;

  always_comb begin
    case (cfg_i.vis_ch)
      CH_RED:   vis_lvl = red_i;
      CH_GREEN: vis_lvl = green_i;
      default:  vis_lvl = blue_i;
    endcase
    case (cfg_i.nir_ch)
      CH_RED:   nir_lvl = red_i;
      CH_GREEN: nir_lvl = green_i;
      default:  nir_lvl = blue_i;
    endcase
    vis_sum  = $signed({2'b00, vis_lvl}) + $signed({cfg_i.vis_off[8], cfg_i.vis_off});
    nir_sum  = $signed({2'b00, nir_lvl}) + $signed({cfg_i.nir_off[8], cfg_i.nir_off});
    vis_pos  = (vis_sum > 10'sd0) ? vis_sum[8:0] : 9'd0;
    nir_pos  = (nir_sum > 10'sd0) ? nir_sum[8:0] : 9'd0;
    vis_prod = {12'd0, vis_pos} * {9'd0, cfg_i.vis_gain};
    nir_prod = {12'd0, nir_pos} * {9'd0, cfg_i.nir_gain};
  end

  assign s1_ready = !s1_valid_q || s2_ready;
  assign s2_ready = !s2_valid_q || ready_i;
  assign ready_o  = s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && valid_i) begin
      s1_vis_q  <= vis_prod;
      s1_nir_q  <= nir_prod;
      s1_mode_q <= cfg_i.mode;
    end
  end

  always_comb begin
    vis_c = (s1_vis_q > {5'd0, SCALED_MAX}) ? SCALED_MAX : s1_vis_q[15:0];
    nir_c = (s1_nir_q > {5'd0, SCALED_MAX}) ? SCALED_MAX : s1_nir_q[15:0];
    neg   = nir_c < vis_c;
    mag   = neg ? (vis_c - nir_c) : (nir_c - vis_c);
    den   = s1_mode_q ? VI_DIVISOR : ({1'b0, nir_c} + {1'b0, vis_c});
    top   = ({1'b0, mag} == den);
    word_d.rem   = top ? '0 : {1'b0, mag};
    word_d.den   = den;
    word_d.neg   = neg;
    word_d.undef = !s1_mode_q && (den == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_valid_q) begin
      s2_word_q <= word_d;
      s2_top_q  <= top;
    end
  end

  assign valid_o = s2_valid_q;
  assign word_o  = s2_word_q;
  assign quo_o   = QW'(s2_top_q);

endmodule

// ===== rtl/vip_div_cell.sv =====
`timescale 1ns / 1ps
module vip_div_cell import vip_pkg::*; #(
  parameter int QW = 15
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  div_word_t     word_i,
  input  logic [QW-1:0] quo_i,
  output logic          valid_o,
  input  logic          ready_i,
  output div_word_t     word_o,
  output logic [QW-1:0] quo_o
);

  logic              valid_q;
  div_word_t         word_q;
  logic [QW-1:0]     quo_q;
  logic [REM_W:0]    rem2;
  logic [REM_W:0]    diff;
  logic              ge;
  div_word_t         word_d;

  always_comb begin
    rem2   = {word_i.rem, 1'b0};
    ge     = rem2 >= {1'b0, word_i.den};
    diff   = rem2 - {1'b0, word_i.den};
    word_d = word_i;
    word_d.rem = ge ? diff[REM_W-1:0] : rem2[REM_W-1:0];
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      word_q <= word_d;
      quo_q  <= {quo_i[QW-2:0], ge};
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;
  assign quo_o   = quo_q;

endmodule
